/* rtl/ctsu_pkg.sv */
// Shared types, token codes and lookup functions for the C subset token scanner.
`default_nettype none
package ctsu_pkg;

  localparam int TOKEN_BUF_BYTES = 256;
  localparam logic [7:0] TXT_MAX = 8'(TOKEN_BUF_BYTES - 2);

  typedef logic [6:0] kind_t;

  localparam kind_t K_EOF     = 7'd0;
  localparam kind_t K_IDENT   = 7'd1;
  localparam kind_t K_INT     = 7'd2;
  localparam kind_t K_CHAR    = 7'd3;
  localparam kind_t K_STRING  = 7'd4;
  localparam kind_t K_KW_BASE = 7'd5;
  localparam kind_t K_LPAREN  = 7'd37;
  localparam kind_t K_RPAREN  = 7'd38;
  localparam kind_t K_LBRACE  = 7'd39;
  localparam kind_t K_RBRACE  = 7'd40;
  localparam kind_t K_LBRACK  = 7'd41;
  localparam kind_t K_RBRACK  = 7'd42;
  localparam kind_t K_SEMI    = 7'd43;
  localparam kind_t K_COMMA   = 7'd44;
  localparam kind_t K_DOT     = 7'd45;
  localparam kind_t K_QUEST   = 7'd46;
  localparam kind_t K_COLON   = 7'd47;
  localparam kind_t K_PLUS    = 7'd48;
  localparam kind_t K_STAR    = 7'd49;
  localparam kind_t K_SLASH   = 7'd50;
  localparam kind_t K_PERCENT = 7'd51;
  localparam kind_t K_CARET   = 7'd52;
  localparam kind_t K_TILDE   = 7'd53;
  localparam kind_t K_NE      = 7'd54;
  localparam kind_t K_NOT     = 7'd55;
  localparam kind_t K_EQEQ    = 7'd56;
  localparam kind_t K_ASSIGN  = 7'd57;
  localparam kind_t K_LE      = 7'd58;
  localparam kind_t K_SHL     = 7'd59;
  localparam kind_t K_LT      = 7'd60;
  localparam kind_t K_GE      = 7'd61;
  localparam kind_t K_SHR     = 7'd62;
  localparam kind_t K_GT      = 7'd63;
  localparam kind_t K_ANDAND  = 7'd64;
  localparam kind_t K_AMP     = 7'd65;
  localparam kind_t K_OROR    = 7'd66;
  localparam kind_t K_PIPE    = 7'd67;
  localparam kind_t K_ARROW   = 7'd68;
  localparam kind_t K_MINUS   = 7'd69;

  localparam logic RT_TOKEN = 1'b0;
  localparam logic RT_TEXT  = 1'b1;

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_SLASH      = 13'b0000000000010,
    M_BLOCK      = 13'b0000000000100,
    M_BLOCK_STAR = 13'b0000000001000,
    M_LINE       = 13'b0000000010000,
    M_IDENT      = 13'b0000000100000,
    M_NUMBER     = 13'b0000001000000,
    M_STRING     = 13'b0000010000000,
    M_STRING_ESC = 13'b0000100000000,
    M_CHAR_OPEN  = 13'b0001000000000,
    M_CHAR_ESC   = 13'b0010000000000,
    M_CHAR_CLOSE = 13'b0100000000000,
    M_PUNCT      = 13'b1000000000000
  } mode_t;

  typedef enum logic [1:0] {
    R_DEC      = 2'd0,
    R_OCT      = 2'd1,
    R_HEX      = 2'd2,
    R_LEADZERO = 2'd3
  } radix_t;

  typedef struct packed {
    logic        rtype;
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  tbyte;
    logic [7:0]  len;
    logic [19:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

  function automatic logic [63:0] kw_word(input logic [4:0] k);
    logic [63:0] w;
    case (k)
      5'd0:  w = "auto";
      5'd1:  w = "break";
      5'd2:  w = "case";
      5'd3:  w = "char";
      5'd4:  w = "const";
      5'd5:  w = "continue";
      5'd6:  w = "default";
      5'd7:  w = "do";
      5'd8:  w = "double";
      5'd9:  w = "else";
      5'd10: w = "enum";
      5'd11: w = "extern";
      5'd12: w = "float";
      5'd13: w = "for";
      5'd14: w = "goto";
      5'd15: w = "if";
      5'd16: w = "int";
      5'd17: w = "long";
      5'd18: w = "register";
      5'd19: w = "return";
      5'd20: w = "short";
      5'd21: w = "signed";
      5'd22: w = "sizeof";
      5'd23: w = "static";
      5'd24: w = "struct";
      5'd25: w = "switch";
      5'd26: w = "typedef";
      5'd27: w = "union";
      5'd28: w = "unsigned";
      5'd29: w = "void";
      5'd30: w = "volatile";
      5'd31: w = "while";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] kw_len(input logic [4:0] k);
    logic [7:0] l;
    case (k)
      5'd7, 5'd15: l = 8'd2;
      5'd13, 5'd16: l = 8'd3;
      5'd0, 5'd2, 5'd3, 5'd9, 5'd10, 5'd14, 5'd17, 5'd29: l = 8'd4;
      5'd1, 5'd4, 5'd12, 5'd20, 5'd27, 5'd31: l = 8'd5;
      5'd8, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: l = 8'd6;
      5'd6, 5'd26: l = 8'd7;
      5'd5, 5'd18, 5'd28, 5'd30: l = 8'd8;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "?": k = K_QUEST;
      ":": k = K_COLON;
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "%": k = K_PERCENT;
      "^": k = K_CARET;
      "~": k = K_TILDE;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic kind_t lone_kind(input logic [7:0] p);
    kind_t k;
    case (p)
      "!": k = K_NOT;
      "=": k = K_ASSIGN;
      "<": k = K_LT;
      ">": k = K_GT;
      "&": k = K_AMP;
      "|": k = K_PIPE;
      default: k = K_MINUS;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
    kind_t k;
    k = K_EOF;
    if (p == "!" && c == "=") k = K_NE;
    if (p == "=" && c == "=") k = K_EQEQ;
    if (p == "<" && c == "=") k = K_LE;
    if (p == "<" && c == "<") k = K_SHL;
    if (p == ">" && c == "=") k = K_GE;
    if (p == ">" && c == ">") k = K_SHR;
    if (p == "&" && c == "&") k = K_ANDAND;
    if (p == "|" && c == "|") k = K_OROR;
    if (p == "-" && c == ">") k = K_ARROW;
    return k;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      "n": d = 8'd10;
      "t": d = 8'd9;
      "r": d = 8'd13;
      default: d = c;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/ctsu_core.sv */
// Scanner state and per-byte next-state logic; yields up to two results per beat.
`default_nettype none
module ctsu_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_of_input,
  output ctsu_pkg::res_t     res0,
  output ctsu_pkg::res_t     res1,
  output logic [1:0]         res_n
);
  import ctsu_pkg::*;

  mode_t       mode, mode_next;
  logic [7:0]  pchar, pchar_next;
  logic [7:0]  tcount, tcount_next;
  logic [31:0] accum, accum_next;
  radix_t      radix, radix_next;
  logic        stopped, stopped_next;
  logic [63:0] kwin, kwin_next;
  logic [19:0] line_count, line_count_next;
  logic [15:0] col_count, col_count_next;
  logic [19:0] tline, tline_next;
  logic [15:0] tcol, tcol_next;

  res_t        q [2];
  logic [1:0]  n;
  res_t        fl;
  logic        fl_v;
  kind_t       id_kind;

  function automatic res_t mk(input logic rt, input kind_t k, input logic [31:0] v,
                              input logic [7:0] b, input logic [7:0] l,
                              input logic [19:0] ln, input logic [15:0] cl);
    res_t r;
    r.rtype = rt; r.kind = k; r.value = v; r.tbyte = b; r.len = l;
    r.line = ln; r.col = cl; r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  always_comb begin
    id_kind = K_IDENT;
    if (tcount <= 8'd8) begin
      for (int k = 0; k < 32; k++) begin
        if (kw_len(5'(k)) == tcount && kw_word(5'(k)) == kwin) id_kind = K_KW_BASE + 7'(k);
      end
    end
  end

  always_comb begin
    fl_v = 1'b1;
    fl = mk(RT_TOKEN, K_EOF, 32'd0, 8'd0, 8'd0, tline, tcol);
    case (mode)
      M_SLASH:                fl.kind = K_SLASH;
      M_IDENT:                begin fl.kind = id_kind; fl.len = tcount; end
      M_NUMBER:               begin fl.kind = K_INT; fl.value = accum; fl.len = tcount; end
      M_STRING, M_STRING_ESC: begin fl.kind = K_STRING; fl.len = tcount; end
      M_CHAR_OPEN, M_CHAR_ESC: fl.kind = K_CHAR;
      M_CHAR_CLOSE:           begin fl.kind = K_CHAR; fl.value = {24'd0, pchar}; end
      M_PUNCT:                fl.kind = lone_kind(pchar);
      default:                fl_v = 1'b0;
    endcase
  end

  always_comb begin
    logic        do_flush, do_start, sp;
    logic [7:0]  c, b, d;
    logic [15:0] mcol;
    kind_t       k;
    res_t        x;
    mode_next = mode; pchar_next = pchar; tcount_next = tcount; accum_next = accum;
    radix_next = radix; stopped_next = stopped; kwin_next = kwin;
    line_count_next = line_count; col_count_next = col_count;
    tline_next = tline; tcol_next = tcol;
    q[0] = '0; q[1] = '0; n = 2'd0;
    do_flush = 1'b0; do_start = 1'b0;
    c = in_byte; b = 8'd0; d = 8'd0; k = K_EOF; x = '0; mcol = 16'd1;
    sp = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

    if (end_of_input) begin
      if (fl_v) begin q[n[0]] = fl; n = n + 2'd1; end
      mode_next = M_IDLE;
      tline_next = line_count;
      mcol = (col_count == 16'd0) ? 16'd1 : col_count;
      tcol_next = mcol;
      q[n[0]] = mk(RT_TOKEN, K_EOF, 32'd0, 8'd0, 8'd0, line_count, mcol);
      n = n + 2'd1;
    end else begin
      if (c == 8'd10) begin
        if (line_count != 20'hFFFFF) line_count_next = line_count + 20'd1;
        col_count_next = 16'd0;
      end else if (col_count != 16'hFFFF) begin
        col_count_next = col_count + 16'd1;
      end

      b = c;
      if (mode == M_STRING_ESC) b = decode_escape(c);
      case (mode)
        M_SLASH: begin
          if (c == "*") mode_next = M_BLOCK;
          else if (c == "/") mode_next = M_LINE;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        M_BLOCK: if (c == "*") mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode_next = M_IDLE;
          else if (c != "*") mode_next = M_BLOCK;
        end
        M_LINE: if (c == 8'd10) mode_next = M_IDLE;
        M_IDENT, M_NUMBER, M_STRING, M_STRING_ESC: begin
          if ((mode == M_IDENT && !(is_alpha(c) || is_digit(c) || c == "_")) ||
              (mode == M_NUMBER && !(is_alpha(c) || is_digit(c)))) begin
            do_flush = 1'b1; do_start = 1'b1;
          end else if (mode == M_STRING && c == "\"") begin
            do_flush = 1'b1;
          end else if (mode == M_STRING && c == "\\") begin
            mode_next = M_STRING_ESC;
          end else begin
            if (mode == M_STRING_ESC) mode_next = M_STRING;
            if (tcount < TXT_MAX) begin
              if (tcount < 8'd8) kwin_next = {kwin[55:0], b};
              tcount_next = tcount + 8'd1;
              k = (mode == M_IDENT) ? K_IDENT : ((mode == M_NUMBER) ? K_INT : K_STRING);
              q[n[0]] = mk(RT_TEXT, k, 32'd0, b, tcount + 8'd1, tline, tcol);
              n = n + 2'd1;
              if (mode == M_NUMBER) begin
                if (radix == R_LEADZERO && (c == "x" || c == "X")) begin
                  radix_next = R_HEX;
                end else begin
                  if (radix == R_LEADZERO) radix_next = R_OCT;
                  if (!stopped) begin
                    if (is_digit(c)) d = c - "0";
                    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
                    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
                    else stopped_next = 1'b1;
                    if (!stopped_next) begin
                      if (radix == R_HEX) accum_next = {accum[27:0], 4'd0} + {24'd0, d};
                      else if (radix == R_DEC)
                        accum_next = {accum[28:0], 3'd0} + {accum[30:0], 1'b0} + {24'd0, d};
                      else accum_next = {accum[28:0], 3'd0} + {24'd0, d};
                    end
                  end
                end
              end
            end
          end
        end
        M_CHAR_OPEN: begin
          if (c == "\\") mode_next = M_CHAR_ESC;
          else begin pchar_next = c; mode_next = M_CHAR_CLOSE; end
        end
        M_CHAR_ESC: begin
          pchar_next = decode_escape(c);
          mode_next = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          do_flush = 1'b1;
          do_start = (c != "'");
        end
        M_PUNCT: begin
          k = pair_kind(pchar, c);
          if (k != K_EOF) begin
            q[n[0]] = mk(RT_TOKEN, k, 32'd0, 8'd0, 8'd0, tline, tcol);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            do_flush = 1'b1; do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_flush) begin
        if (fl_v) begin q[n[0]] = fl; n = n + 2'd1; end
        mode_next = M_IDLE;
      end

      if (do_start) begin
        mode_next = M_IDLE;
        if (!sp) begin
          mcol = (col_count_next == 16'd0) ? 16'd1 : col_count_next;
          tline_next = line_count_next;
          tcol_next = mcol;
          tcount_next = 8'd0;
          kwin_next = 64'd0;
          x = mk(RT_TOKEN, K_EOF, 32'd0, 8'd0, 8'd0, line_count_next, mcol);
          if (c == "/") begin
            mode_next = M_SLASH;
          end else if (is_alpha(c) || c == "_" || is_digit(c)) begin
            kwin_next = {56'd0, c};
            tcount_next = 8'd1;
            x.rtype = RT_TEXT; x.tbyte = c; x.len = 8'd1;
            if (is_digit(c)) begin
              mode_next = M_NUMBER;
              stopped_next = 1'b0;
              radix_next = (c == "0") ? R_LEADZERO : R_DEC;
              accum_next = {24'd0, c - "0"};
              x.kind = K_INT;
            end else begin
              mode_next = M_IDENT;
              x.kind = K_IDENT;
            end
            q[n[0]] = x; n = n + 2'd1;
          end else if (c == "\"") begin
            mode_next = M_STRING;
          end else if (c == "'") begin
            mode_next = M_CHAR_OPEN;
            pchar_next = 8'd0;
          end else if (single_kind(c) != K_EOF) begin
            x.kind = single_kind(c);
            q[n[0]] = x; n = n + 2'd1;
          end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "&" ||
                       c == "|" || c == "-") begin
            mode_next = M_PUNCT;
            pchar_next = c;
          end else begin
            q[n[0]] = x; n = n + 2'd1;
          end
        end
      end
    end

    if (n == 2'd2) q[1].last = 1'b1;
    else if (n == 2'd1) q[0].last = 1'b1;
  end

  assign res0  = q[0];
  assign res1  = q[1];
  assign res_n = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pchar <= 8'd0; tcount <= 8'd0; accum <= 32'd0;
      radix <= R_DEC; stopped <= 1'b0; kwin <= 64'd0;
      line_count <= 20'd1; col_count <= 16'd0; tline <= 20'd1; tcol <= 16'd1;
    end else if (step) begin
      mode <= mode_next; pchar <= pchar_next; tcount <= tcount_next;
      accum <= accum_next; radix <= radix_next; stopped <= stopped_next;
      kwin <= kwin_next; line_count <= line_count_next; col_count <= col_count_next;
      tline <= tline_next; tcol <= tcol_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/c_subset_token_scanner_unit.sv */
// Top level of the C subset token scanner: scanner core and four-entry result queue.
//
//  channel | signals                                    | dir | beat
//  in      | in_valid in_ready in_byte end_of_input     | in  | one source byte or end mark
//  out     | out_valid out_ready result_type token_kind | out | one token or text byte
//          | token_value text_byte token_length         |     |
//          | start_line start_col last                  |     |
//
// One input beat per cycle while the result queue has room for two entries.
// Each beat yields zero, one or two results; the single output port drains one per
// cycle while out_ready is high, so beats with two results set the sustained rate when output is the limit.
// Synchronous reset returns the scanner to idle at line 1, column 0 and empties the queue.
// A stalled output only backs up the queue; input stalls once fewer than two slots are free.
`default_nettype none
module c_subset_token_scanner_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  end_of_input,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       result_type,
  output ctsu_pkg::kind_t            token_kind,
  output logic [31:0]                token_value,
  output logic [7:0]                 text_byte,
  output logic [7:0]                 token_length,
  output logic [19:0]                start_line,
  output logic [15:0]                start_col,
  output logic                       last
);
  import ctsu_pkg::*;

  res_t       r0, r1, head;
  logic [1:0] rn;
  logic       step, pop;
  res_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign in_ready = (cnt <= 3'd2);
  assign step     = in_valid && in_ready;
  assign out_valid = (cnt != 3'd0);
  assign pop      = out_valid && out_ready;

  ctsu_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .res0         (r0),
    .res1         (r1),
    .res_n        (rn)
  );

  always_ff @(posedge clk) begin
    if (step && rn != 2'd0) q[wp] <= r0;
    if (step && rn == 2'd2) q[wp + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0; rp <= 2'd0; cnt <= 3'd0;
    end else begin
      if (step) wp <= wp + rn;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + (step ? {1'b0, rn} : 3'd0) - {2'd0, pop};
    end
  end

  assign head         = q[rp];
  assign result_type  = head.rtype;
  assign token_kind   = head.kind;
  assign token_value  = head.value;
  assign text_byte    = head.tbyte;
  assign token_length = head.len;
  assign start_line   = head.line;
  assign start_col    = head.col;
  assign last         = head.last;

endmodule
`default_nettype wire

/* rtl/ctsu_checker.sv */
// Port-level assertions for the token scanner, bound to the top level.
`default_nettype none
module ctsu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        end_of_input,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        result_type,
  input wire logic [6:0]  token_kind,
  input wire logic [7:0]  text_byte
);
  import ctsu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_input |=> out_valid)
    else $error("end mark produced no result");

  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_type == RT_TEXT |->
      token_kind == K_IDENT || token_kind == K_INT || token_kind == K_STRING)
    else $error("text beat with bad kind");

  a_token_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_type == RT_TOKEN |-> text_byte == 8'd0)
    else $error("token beat carries text byte");

endmodule

bind c_subset_token_scanner_unit ctsu_checker u_ctsu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .end_of_input (end_of_input),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_type  (result_type),
  .token_kind   (token_kind),
  .text_byte    (text_byte)
);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the C subset token scanner unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctsu_pkg::*;

  localparam int SCAN_MODE_IDLE = 0;
  localparam int SCAN_MODE_SLASH = 1;
  localparam int SCAN_MODE_BLOCK = 2;
  localparam int SCAN_MODE_BLOCK_STAR = 3;
  localparam int SCAN_MODE_LINE = 4;
  localparam int SCAN_MODE_IDENT = 5;
  localparam int SCAN_MODE_NUMBER = 6;
  localparam int SCAN_MODE_STRING = 7;
  localparam int SCAN_MODE_STRING_ESC = 8;
  localparam int SCAN_MODE_CHAR_OPEN = 9;
  localparam int SCAN_MODE_CHAR_ESC = 10;
  localparam int SCAN_MODE_CHAR_CLOSE = 11;
  localparam int SCAN_MODE_PUNCT = 12;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst;
  logic in_valid, in_ready, end_of_input, out_valid, out_ready;
  logic [7:0] in_byte;
  logic result_type, last;
  kind_t token_kind;
  logic [31:0] token_value;
  logic [7:0] text_byte, token_length;
  logic [19:0] start_line;
  logic [15:0] start_col;

  c_subset_token_scanner_unit i_dut (.*);

  // scanner state mirror
  int          sc_mode;
  logic [7:0]  sc_pend;
  int          sc_count;
  logic [31:0] sc_accum;
  radix_t      sc_radix;
  logic        sc_stopped;
  logic [63:0] sc_kwin;
  logic [19:0] sc_line, sc_tline;
  logic [15:0] sc_col, sc_tcol;

  res_t beat_res[$];
  res_t token_results[$];
  int   errors = 0;
  bit   stim_done = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic void emit(logic rt, kind_t k, logic [31:0] v, logic [7:0] b,
                               logic [7:0] l);
    res_t r;
    if (beat_res.size() >= 2) return;
    r.rtype = rt; r.kind = k; r.value = v; r.tbyte = b; r.len = l;
    r.line = sc_tline; r.col = sc_tcol; r.last = 1'b0;
    beat_res.push_back(r);
  endfunction

  function automatic void mark_token_start();
    sc_tline = sc_line;
    sc_tcol = (sc_col != 0) ? sc_col : 16'd1;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit store_text(logic [7:0] c, kind_t cls);
    if (sc_count + 2 >= TOKEN_BUF_BYTES) return 0;
    if (sc_count < 8) sc_kwin = {sc_kwin[55:0], c};
    sc_count++;
    emit(RT_TEXT, cls, 0, c, 8'(sc_count));
    return 1;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "n": return 8'd10;
      "t": return 8'd9;
      "r": return 8'd13;
      default: return c;
    endcase
  endfunction

  function automatic kind_t word_kind();
    logic [63:0] w;
    int n;
    string kws[32] = '{"auto", "break", "case", "char", "const", "continue", "default",
      "do", "double", "else", "enum", "extern", "float", "for", "goto", "if", "int",
      "long", "register", "return", "short", "signed", "sizeof", "static", "struct",
      "switch", "typedef", "union", "unsigned", "void", "volatile", "while"};
    if (sc_count > 8) return K_IDENT;
    for (int k = 0; k < 32; k++) begin
      w = '0;
      n = kws[k].len();
      for (int i = 0; i < n; i++) w = {w[55:0], 8'(kws[k][i])};
      if (n == sc_count && w == sc_kwin) return kind_t'(K_KW_BASE + k);
    end
    return K_IDENT;
  endfunction

  function automatic kind_t one_char_kind(logic [7:0] c);
    case (c)
      "(": return K_LPAREN;  ")": return K_RPAREN; "{": return K_LBRACE;
      "}": return K_RBRACE;  "[": return K_LBRACK; "]": return K_RBRACK;
      ";": return K_SEMI;    ",": return K_COMMA;  ".": return K_DOT;
      "?": return K_QUEST;   ":": return K_COLON;  "+": return K_PLUS;
      "*": return K_STAR;    "%": return K_PERCENT; "^": return K_CARET;
      "~": return K_TILDE;
      default: return K_EOF;
    endcase
  endfunction

  function automatic kind_t lone_op_kind(logic [7:0] p);
    case (p)
      "!": return K_NOT; "=": return K_ASSIGN; "<": return K_LT;
      ">": return K_GT;  "&": return K_AMP;    "|": return K_PIPE;
      default: return K_MINUS;
    endcase
  endfunction

  function automatic kind_t two_char_kind(logic [7:0] p, logic [7:0] c);
    if (p == "!" && c == "=") return K_NE;
    if (p == "=" && c == "=") return K_EQEQ;
    if (p == "<" && c == "=") return K_LE;
    if (p == "<" && c == "<") return K_SHL;
    if (p == ">" && c == "=") return K_GE;
    if (p == ">" && c == ">") return K_SHR;
    if (p == "&" && c == "&") return K_ANDAND;
    if (p == "|" && c == "|") return K_OROR;
    if (p == "-" && c == ">") return K_ARROW;
    return K_EOF;
  endfunction

  function automatic void accum_digit(logic [7:0] c);
    logic [31:0] d, base;
    if (sc_radix == R_LEADZERO) begin
      if (c == "x" || c == "X") begin
        sc_radix = R_HEX;
        return;
      end
      sc_radix = R_OCT;
    end
    if (sc_stopped) return;
    if (is_dec(c)) d = c - "0";
    else if (c >= "a" && c <= "f") d = 10 + c - "a";
    else if (c >= "A" && c <= "F") d = 10 + c - "A";
    else begin
      sc_stopped = 1;
      return;
    end
    base = (sc_radix == R_HEX) ? 16 : (sc_radix == R_OCT) ? 8 : 10;
    sc_accum = sc_accum * base + d;
  endfunction

  function automatic void close_token();
    case (sc_mode)
      SCAN_MODE_SLASH: emit(RT_TOKEN, K_SLASH, 0, 0, 0);
      SCAN_MODE_IDENT: emit(RT_TOKEN, word_kind(), 0, 0, 8'(sc_count));
      SCAN_MODE_NUMBER: emit(RT_TOKEN, K_INT, sc_accum, 0, 8'(sc_count));
      SCAN_MODE_STRING, SCAN_MODE_STRING_ESC: emit(RT_TOKEN, K_STRING, 0, 0, 8'(sc_count));
      SCAN_MODE_CHAR_OPEN, SCAN_MODE_CHAR_ESC: emit(RT_TOKEN, K_CHAR, 0, 0, 0);
      SCAN_MODE_CHAR_CLOSE: emit(RT_TOKEN, K_CHAR, {24'd0, sc_pend}, 0, 0);
      SCAN_MODE_PUNCT: emit(RT_TOKEN, lone_op_kind(sc_pend), 0, 0, 0);
      default: ;
    endcase
    sc_mode = SCAN_MODE_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] c);
    kind_t k;
    bit ok;
    sc_mode = SCAN_MODE_IDLE;
    if (c == 32 || (c >= 9 && c <= 13)) return;
    mark_token_start();
    sc_count = 0;
    sc_kwin = '0;
    k = one_char_kind(c);
    if (c == "/") sc_mode = SCAN_MODE_SLASH;
    else if (is_letter(c) || c == "_") begin
      sc_mode = SCAN_MODE_IDENT;
      ok = store_text(c, K_IDENT);
    end else if (is_dec(c)) begin
      sc_mode = SCAN_MODE_NUMBER;
      sc_stopped = 0;
      sc_radix = (c == "0") ? R_LEADZERO : R_DEC;
      sc_accum = c - "0";
      ok = store_text(c, K_INT);
    end else if (c == "\"") sc_mode = SCAN_MODE_STRING;
    else if (c == "'") begin
      sc_mode = SCAN_MODE_CHAR_OPEN;
      sc_pend = 0;
    end else if (k != K_EOF) emit(RT_TOKEN, k, 0, 0, 0);
    else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "&" || c == "|" ||
             c == "-") begin
      sc_mode = SCAN_MODE_PUNCT;
      sc_pend = c;
    end else emit(RT_TOKEN, K_EOF, 0, 0, 0);
  endfunction

  function automatic void scan_reset();
    sc_mode = SCAN_MODE_IDLE; sc_pend = 0; sc_count = 0; sc_accum = 0;
    sc_radix = R_DEC; sc_stopped = 0; sc_kwin = 0;
    sc_line = 1; sc_col = 0; sc_tline = 1; sc_tcol = 1;
  endfunction

  // computes the results of one accepted source beat and queues them
  function automatic void scan_beat(logic [7:0] c, logic eoi);
    kind_t k;
    bit ok;
    beat_res.delete();
    if (eoi) begin
      close_token();
      mark_token_start();
      emit(RT_TOKEN, K_EOF, 0, 0, 0);
    end else begin
      if (c == 10) begin
        if (sc_line != 20'hFFFFF) sc_line++;
        sc_col = 0;
      end else if (sc_col != 16'hFFFF) sc_col++;
      case (sc_mode)
        SCAN_MODE_SLASH:
          if (c == "*") sc_mode = SCAN_MODE_BLOCK;
          else if (c == "/") sc_mode = SCAN_MODE_LINE;
          else begin close_token(); open_token(c); end
        SCAN_MODE_BLOCK: if (c == "*") sc_mode = SCAN_MODE_BLOCK_STAR;
        SCAN_MODE_BLOCK_STAR:
          if (c == "/") sc_mode = SCAN_MODE_IDLE;
          else if (c != "*") sc_mode = SCAN_MODE_BLOCK;
        SCAN_MODE_LINE: if (c == 10) sc_mode = SCAN_MODE_IDLE;
        SCAN_MODE_IDENT:
          if (is_letter(c) || is_dec(c) || c == "_") ok = store_text(c, K_IDENT);
          else begin close_token(); open_token(c); end
        SCAN_MODE_NUMBER:
          if (is_letter(c) || is_dec(c)) begin
            if (store_text(c, K_INT)) accum_digit(c);
          end else begin close_token(); open_token(c); end
        SCAN_MODE_STRING:
          if (c == "\"") close_token();
          else if (c == "\\") sc_mode = SCAN_MODE_STRING_ESC;
          else ok = store_text(c, K_STRING);
        SCAN_MODE_STRING_ESC: begin
          ok = store_text(unescape(c), K_STRING);
          sc_mode = SCAN_MODE_STRING;
        end
        SCAN_MODE_CHAR_OPEN:
          if (c == "\\") sc_mode = SCAN_MODE_CHAR_ESC;
          else begin sc_pend = c; sc_mode = SCAN_MODE_CHAR_CLOSE; end
        SCAN_MODE_CHAR_ESC: begin
          sc_pend = unescape(c);
          sc_mode = SCAN_MODE_CHAR_CLOSE;
        end
        SCAN_MODE_CHAR_CLOSE: begin
          close_token();
          if (c != "'") open_token(c);
        end
        SCAN_MODE_PUNCT: begin
          k = two_char_kind(sc_pend, c);
          if (k != K_EOF) begin
            emit(RT_TOKEN, k, 0, 0, 0);
            sc_mode = SCAN_MODE_IDLE;
          end else begin close_token(); open_token(c); end
        end
        default: open_token(c);
      endcase
    end
    if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last = 1'b1;
    foreach (beat_res[i]) token_results.push_back(beat_res[i]);
  endfunction

  logic [7:0] src_bytes[$];
  logic       src_eoi[$];
  logic       src_has_exp[$];
  kind_t      src_exp_kind[$];
  logic [31:0] src_exp_value[$];
  int exp_tag[$];   // per queued result: index of typed expectation or -1

  task automatic add_row(logic [7:0] c, logic e, logic he = 0, kind_t k = K_EOF,
                         logic [31:0] v = 0);
    src_bytes.push_back(c); src_eoi.push_back(e); src_has_exp.push_back(he);
    src_exp_kind.push_back(k); src_exp_value.push_back(v);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(8'(s[i]), 0);
  endtask

  task automatic add_random_item();
    string frags[12] = '{"int ", "while(x>=0x1F){", "a->b", "'\\n'", "\"s\\t\\\"\"",
      "/* c */", "// l\n", "0777 ", "x&&y||z", "return 42;", "!= == << >>", "volatile "};
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) add_text(frags[$urandom_range(0, 11)]);
    else if (r < 8) add_row(8'($urandom_range(32, 126)), 0);
    else if (r == 8) add_row(8'($urandom), 0);
    else if ($urandom_range(0, 9) == 0) add_row(8'($urandom), 1);
    else add_row(8'(" "), 0);
  endtask

  initial begin
    int gap;
    rst = 1; in_valid = 0; in_byte = 0; end_of_input = 0;
    scan_reset();
    // directed: extremes, operators, special cases
    add_row(8'h00, 1, 1, K_EOF, 0);
    add_row(8'hFF, 0, 1, K_EOF, 0);
    add_row(8'h40, 0, 1, K_EOF, 0);
    add_text("auto while 0xFFFFFFFF 08 'a' '\\\\ \"ab\\q");
    add_row(8'h00, 1);
    add_text("(){}[];,.?:+*/%^~ != ! == = <= << < >= >> > && & || | -> - ");
    add_text("4294967296 0Xz9 /* x ** / */ // c\n");
    add_text("'");
    add_row(8'h00, 1);
    add_text("-");
    add_row(8'h00, 1);
    for (int i = 0; i < 300; i++) add_row(8'("a"), 0);  // buffer overflow
    add_row(8'h00, 1);
    while (src_bytes.size() < 1600) add_random_item();
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 0;
    for (int idx = 0; idx < src_bytes.size(); idx++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1; in_byte <= src_bytes[idx]; end_of_input <= src_eoi[idx];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      scan_beat(src_bytes[idx], src_eoi[idx]);
      for (int j = 0; j < beat_res.size(); j++)
        exp_tag.push_back((j == 0 && src_has_exp[idx]) ? idx : -1);
      @(negedge clk);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // receiver pacing with one long hold-off
  initial begin
    int w;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (200) @(negedge clk);
    out_ready <= 0; hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
    forever begin
      w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      if (w != 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t e;
    int tag;
    if (!rst && out_valid && out_ready) begin
      if (token_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $time, token_kind);
        errors++;
      end else begin
        e = token_results.pop_front();
        tag = exp_tag.pop_front();
        if (tag >= 0 && (src_exp_kind[tag] != token_kind || src_exp_value[tag] != token_value))
        begin
          $display("%0t: table exp kind=%0d value=%0h got kind=%0d value=%0h", $time,
                   src_exp_kind[tag], src_exp_value[tag], token_kind, token_value);
          errors++;
        end
        if (e.rtype !== result_type || e.kind !== token_kind || e.value !== token_value ||
            e.tbyte !== text_byte || e.len !== token_length || e.line !== start_line ||
            e.col !== start_col || e.last !== last) begin
          $display("%0t: exp t=%0d k=%0d v=%0h b=%0h l=%0d ln=%0d c=%0d last=%0d", $time,
                   e.rtype, e.kind, e.value, e.tbyte, e.len, e.line, e.col, e.last);
          $display("%0t: got t=%0d k=%0d v=%0h b=%0h l=%0d ln=%0d c=%0d last=%0d", $time,
                   result_type, token_kind, token_value, text_byte, token_length,
                   start_line, start_col, last);
          errors++;
        end
      end
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && token_results.size() == 0) begin
        repeat (20) @(posedge clk);
        if (errors == 0 && token_results.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog timeout", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end
endmodule
